@@ sv/bbcm_pkg.sv @@
// shared types, constants and codes for the block buffer cache manager
// no dependencies; imported by every module of the block
package bbcm_pkg;

  localparam int BUFFER_COUNT = 64;
  localparam int IDX_W = $clog2(BUFFER_COUNT);
  localparam int CNT_W = $clog2(BUFFER_COUNT + 1);
  localparam int DEV_W = 16;
  localparam int BLK_W = 32;
  localparam int XFL_W = 5;
  localparam int CMD_W = 3;
  localparam int STS_W = 4;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET       = 3'd0,
    CMD_START_RD  = 3'd1,
    CMD_START_WR  = 3'd2,
    CMD_RELEASE   = 3'd3,
    CMD_COMPLETE  = 3'd4
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_HIT_VALID  = 4'd0,
    ST_HIT_NVALID = 4'd1,
    ST_ASSIGNED   = 4'd2,
    ST_BUSY       = 4'd3,
    ST_NONE_FREE  = 4'd4,
    ST_WRITEBACK  = 4'd5,
    ST_ACCEPTED   = 4'd6,
    ST_DONE_ERR   = 4'd7,
    ST_FATAL      = 4'd8
  } status_t;

  // entry flag bit positions
  localparam int FB_DIRTY = 0;
  localparam int FB_AGE   = 1;
  localparam int FB_ERROR = 2;
  localparam int FB_ASYNC = 3;
  localparam int FB_CRIT  = 4;
  localparam int FB_VALID = 5;
  localparam int FB_READ  = 6;
  localparam int FB_WRITE = 7;

  typedef struct packed {
    logic [7:0] flags;
    logic       busy;
    logic       wanted;
    logic       done;
  } meta_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic match;
    logic rd;
    logic exe;
    logic ins;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic ld_get;
    logic ld_ok;
    logic none_free;
    logic need_ins;
  } sts_t;

endpackage

@@ sv/bbcm_ctrl.sv @@
// sequencer for the buffer cache manager: clear sweep, then one transaction at a time
// depends on bbcm_pkg
module bbcm_ctrl import bbcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MATCH, S_RD, S_EXE, S_INS, S_OUT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      case (state_r)
        S_CLR:   if (sts.clr_done) state_r <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            if (sts.ld_get)     state_r <= S_MATCH;
            else if (sts.ld_ok) state_r <= S_RD;
            else                state_r <= S_OUT;
          end
        end
        S_MATCH: state_r <= sts.none_free ? S_OUT : S_RD;
        S_RD:    state_r <= S_EXE;
        S_EXE:   state_r <= sts.need_ins ? S_INS : S_OUT;
        S_INS:   state_r <= S_OUT;
        S_OUT:   if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_CLR;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    ctl       = '0;
    ctl.clr   = (state_r == S_CLR);
    ctl.load  = (state_r == S_IDLE) && in_valid;
    ctl.match = (state_r == S_MATCH);
    ctl.rd    = (state_r == S_RD);
    ctl.exe   = (state_r == S_EXE);
    ctl.ins   = (state_r == S_INS);
  end

endmodule

@@ sv/bbcm_dp.sv @@
// datapath: tag lanes with associative compare, entry state and free list memories
// depends on bbcm_pkg; driven by bbcm_ctrl
module bbcm_dp import bbcm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  output sts_t             sts,
  input  logic [CMD_W-1:0] in_command,
  input  logic [5:0]       in_buffer_index,
  input  logic [DEV_W-1:0] in_device,
  input  logic [BLK_W-1:0] in_block_number,
  input  logic [XFL_W-1:0] in_flag_bits,
  output logic [STS_W-1:0] status,
  output logic [5:0]       result_index,
  output logic [DEV_W-1:0] victim_device,
  output logic [BLK_W-1:0] victim_block,
  output logic             wake_owner,
  output logic             wake_any
);

  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [DEV_W-1:0] dev_r;
  logic [BLK_W-1:0] blk_r;
  logic [XFL_W-1:0] fl_r;
  logic             hit_r;
  logic             ins_head_r;
  logic [IDX_W-1:0] head_r, tail_r, clr_cnt_r;
  logic [CNT_W-1:0] count_r;
  logic [BUFFER_COUNT-1:0] assigned_r;
  logic [DEV_W-1:0] tag_dev_r [BUFFER_COUNT];
  logic [BLK_W-1:0] tag_blk_r [BUFFER_COUNT];

  meta_t            meta_mem [BUFFER_COUNT];
  logic [IDX_W-1:0] next_mem [BUFFER_COUNT];
  logic [IDX_W-1:0] prev_mem [BUFFER_COUNT];
  meta_t            meta_q;
  logic [IDX_W-1:0] next_q, prev_q;

  logic [STS_W-1:0] status_r;
  logic [IDX_W-1:0] ridx_r;
  logic [DEV_W-1:0] vdev_r;
  logic [BLK_W-1:0] vblk_r;
  logic             wo_r, wa_r;

  // associative compare, lowest index wins
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int j = BUFFER_COUNT - 1; j >= 0; j--) begin
      if (assigned_r[j] && tag_dev_r[j] == dev_r && tag_blk_r[j] == blk_r) begin
        hit = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  // next-state logic for execute and insert steps
  meta_t            m;
  logic [7:0]       relf, f;
  logic             rel, rm, aged, wo, wa;
  logic [STS_W-1:0] st;
  logic             tag_we;
  logic [IDX_W-1:0] head_nxt, tail_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             nx_we, pv_we;
  logic [IDX_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

  always_comb begin
    m = meta_q;
    relf = '0;
    f = '0;
    rel = 1'b0;
    rm = 1'b0;
    aged = 1'b0;
    wo = 1'b0;
    wa = 1'b0;
    st = ST_ACCEPTED;
    tag_we = 1'b0;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = count_r;
    nx_we = 1'b0;
    pv_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    pv_wa = '0;
    pv_wd = '0;
    if (ctl.exe) begin
      case (cmd_r)
        CMD_GET: begin
          if (hit_r && meta_q.busy) begin
            m.wanted = 1'b1;
            st = ST_BUSY;
          end else begin
            m.busy = 1'b1;
            rm = 1'b1;
            if (hit_r) begin
              st = meta_q.flags[FB_VALID] ? ST_HIT_VALID : ST_HIT_NVALID;
            end else if (meta_q.flags[FB_DIRTY]) begin
              m.done = 1'b0;
              m.flags[FB_READ]  = 1'b0;
              m.flags[FB_WRITE] = 1'b1;
              m.flags[FB_ASYNC] = 1'b1;
              m.flags[FB_AGE]   = 1'b1;
              st = ST_WRITEBACK;
            end else begin
              m.flags = '0;
              tag_we = 1'b1;
              st = ST_ASSIGNED;
            end
          end
        end
        CMD_START_RD: begin
          m.done = 1'b0;
          m.flags = meta_q.flags | {3'b000, fl_r};
          m.flags[FB_WRITE] = 1'b0;
          m.flags[FB_READ]  = 1'b1;
        end
        CMD_START_WR: begin
          m.done = 1'b0;
          m.flags = meta_q.flags | {3'b000, fl_r};
          m.flags[FB_READ]  = 1'b0;
          m.flags[FB_WRITE] = 1'b1;
        end
        CMD_RELEASE: begin
          rel = 1'b1;
          relf = meta_q.flags | {3'b000, fl_r};
        end
        CMD_COMPLETE: begin
          f = meta_q.flags | {3'b000, fl_r};
          if (f[FB_ERROR] && f[FB_CRIT]) begin
            m.flags = f;
            st = ST_FATAL;
          end else begin
            if (f[FB_READ]) f[FB_VALID] = 1'b1;
            else            f[FB_DIRTY] = 1'b0;
            f[FB_READ]  = 1'b0;
            f[FB_WRITE] = 1'b0;
            f[FB_CRIT]  = 1'b0;
            if (f[FB_ASYNC]) begin
              f[FB_ASYNC] = 1'b0;
              f[FB_ERROR] = 1'b0;
              rel = 1'b1;
              relf = f;
            end else begin
              m.flags = f;
              m.done = 1'b1;
              m.wanted = 1'b0;
              wo = 1'b1;
              st = f[FB_ERROR] ? ST_DONE_ERR : ST_ACCEPTED;
            end
          end
        end
        default: ;
      endcase
      if (rel) begin
        rm = !meta_q.busy;
        m.busy = 1'b0;
        wo = meta_q.wanted;
        m.wanted = 1'b0;
        aged = relf[FB_AGE];
        m.flags = relf;
        m.flags[FB_AGE] = 1'b0;
      end
      // unlink from the free list
      if (rm && count_r != '0) begin
        if (count_r == CNT_W'(1)) begin
          cnt_nxt = '0;
        end else begin
          if (idx_r == head_r) begin
            head_nxt = next_q;
          end else if (idx_r == tail_r) begin
            tail_nxt = prev_q;
          end else begin
            nx_we = 1'b1;
            nx_wa = prev_q;
            nx_wd = next_q;
            pv_we = 1'b1;
            pv_wa = next_q;
            pv_wd = prev_q;
          end
          cnt_nxt = count_r - CNT_W'(1);
        end
      end
      wa = rel && (cnt_nxt == '0);
    end else if (ctl.ins) begin
      // link back in, at the head when aged
      if (count_r == '0) begin
        head_nxt = idx_r;
        tail_nxt = idx_r;
      end else if (ins_head_r) begin
        nx_we = 1'b1;
        nx_wa = idx_r;
        nx_wd = head_r;
        pv_we = 1'b1;
        pv_wa = head_r;
        pv_wd = idx_r;
        head_nxt = idx_r;
      end else begin
        pv_we = 1'b1;
        pv_wa = idx_r;
        pv_wd = tail_r;
        nx_we = 1'b1;
        nx_wa = tail_r;
        nx_wd = idx_r;
        tail_nxt = idx_r;
      end
      cnt_nxt = count_r + CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      head_r     <= '0;
      tail_r     <= IDX_W'(BUFFER_COUNT - 1);
      count_r    <= CNT_W'(BUFFER_COUNT);
      assigned_r <= '0;
    end else begin
      if (ctl.clr) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= cnt_nxt;
      if (tag_we) assigned_r[idx_r] <= 1'b1;
    end
  end

  // payload registers and memories
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      meta_mem[clr_cnt_r]  <= '0;
      next_mem[clr_cnt_r]  <= clr_cnt_r + IDX_W'(1);
      prev_mem[clr_cnt_r]  <= clr_cnt_r - IDX_W'(1);
      tag_dev_r[clr_cnt_r] <= '0;
      tag_blk_r[clr_cnt_r] <= BLK_W'(clr_cnt_r);
    end else begin
      if (ctl.exe) meta_mem[idx_r] <= m;
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (tag_we) begin
        tag_dev_r[idx_r] <= dev_r;
        tag_blk_r[idx_r] <= blk_r;
      end
    end
    if (ctl.rd) begin
      meta_q <= meta_mem[idx_r];
      next_q <= next_mem[idx_r];
      prev_q <= prev_mem[idx_r];
    end
    if (ctl.load) begin
      cmd_r    <= in_command;
      idx_r    <= IDX_W'(in_buffer_index);
      dev_r    <= in_device;
      blk_r    <= in_block_number;
      fl_r     <= in_flag_bits;
      status_r <= ST_ACCEPTED;
      ridx_r   <= '0;
      vdev_r   <= '0;
      vblk_r   <= '0;
      wo_r     <= 1'b0;
      wa_r     <= 1'b0;
    end
    if (ctl.match) begin
      hit_r <= hit;
      idx_r <= hit ? hit_idx : head_r;
      if (!hit && count_r == '0) status_r <= ST_NONE_FREE;
    end
    if (ctl.exe) begin
      ins_head_r <= aged;
      status_r   <= st;
      ridx_r     <= idx_r;
      wo_r       <= wo;
      wa_r       <= wa;
      if (st == ST_WRITEBACK) begin
        vdev_r <= tag_dev_r[idx_r];
        vblk_r <= tag_blk_r[idx_r];
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.clr_done  = (clr_cnt_r == IDX_W'(BUFFER_COUNT - 1));
    sts.ld_get    = (in_command == CMD_GET);
    sts.ld_ok     = (in_command == CMD_START_RD) || (in_command == CMD_START_WR) ||
                    (in_command == CMD_RELEASE) || (in_command == CMD_COMPLETE);
    sts.none_free = !hit && (count_r == '0);
    sts.need_ins  = rel;
  end

  assign status        = status_r;
  assign result_index  = 6'(ridx_r);
  assign victim_device = vdev_r;
  assign victim_block  = vblk_r;
  assign wake_owner    = wo_r;
  assign wake_any      = wa_r;

endmodule

@@ sv/block_buffer_cache_manager.sv @@
// top level of the block buffer cache manager: stream ports, field packing
// depends on bbcm_pkg, bbcm_ctrl and bbcm_dp
//
//  channel  | ports               | transaction
//  ---------+---------------------+-------------------------------------------
//  in       | in_tvalid/tready    | one command (get, start, release, complete)
//  out      | out_tvalid/tready   | one result per command
//
// after reset a clearing pass initializes the entry memories, no command taken
// a get steps through compare, read, execute and output, skipping read and execute
// when no entry is free; start and sync complete step through read, execute, output;
// release and async complete add a relink step; an unknown command goes straight to output
// one transaction is in flight at a time; a held result stalls the input
module block_buffer_cache_manager import bbcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command[2:0], buffer_index[8:3], device[24:9], block_number[56:25], flag_bits[61:57]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[3:0], result_index[9:4], victim_device[25:10], victim_block[57:26],
  // wake_owner[58], wake_any[59]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ctl_t ctl;
  sts_t sts;

  logic [STS_W-1:0] status;
  logic [5:0]       result_index;
  logic [DEV_W-1:0] victim_device;
  logic [BLK_W-1:0] victim_block;
  logic             wake_owner, wake_any;

  // sequencer
  bbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // tag lanes, entry state, free list
  bbcm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_tdata[2:0]),
    .in_buffer_index (in_tdata[8:3]),
    .in_device       (in_tdata[24:9]),
    .in_block_number (in_tdata[56:25]),
    .in_flag_bits    (in_tdata[61:57]),
    .status          (status),
    .result_index    (result_index),
    .victim_device   (victim_device),
    .victim_block    (victim_block),
    .wake_owner      (wake_owner),
    .wake_any        (wake_any)
  );

  // pack result fields, lowest first, zero fill to whole bytes
  assign out_tdata = {4'b0000, wake_any, wake_owner, victim_block, victim_device,
                      result_index, status};

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the block buffer cache manager
// depends on bbcm_pkg and block_buffer_cache_manager; drives command
// transactions, predicts each result and compares it field by field
module testbench;
  import bbcm_pkg::*;

  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [XFL_W-1:0] xfl;
    logic [BLK_W-1:0] blk;
    logic [DEV_W-1:0] dev;
    logic [IDX_W-1:0] idx;
    logic [CMD_W-1:0] cmd;
  } cmd_item_t;

  typedef struct packed {
    logic             wa;
    logic             wo;
    logic [BLK_W-1:0] vblk;
    logic [DEV_W-1:0] vdev;
    logic [IDX_W-1:0] idx;
    logic [STS_W-1:0] sts;
  } result_t;

  // flag masks
  localparam logic [7:0] M_DIRTY = 8'h01, M_AGE = 8'h02, M_ERROR = 8'h04;
  localparam logic [7:0] M_ASYNC = 8'h08, M_CRIT = 8'h10, M_VALID = 8'h20;
  localparam logic [7:0] M_READ = 8'h40, M_WRITE = 8'h80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  block_buffer_cache_manager u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the cache state
  logic [DEV_W-1:0] c_dev [BUFFER_COUNT];
  logic [BLK_W-1:0] c_blk [BUFFER_COUNT];
  logic             c_asg [BUFFER_COUNT];
  logic [7:0]       c_fl  [BUFFER_COUNT];
  logic             c_busy[BUFFER_COUNT];
  logic             c_want[BUFFER_COUNT];
  logic             c_done[BUFFER_COUNT];
  int               lru_next[BUFFER_COUNT];
  int               lru_prev[BUFFER_COUNT];
  int               lru_head, lru_tail, lru_count;

  cmd_item_t pending_cmds[$];
  result_t   expected_results[$];
  int        n_fail = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        cycle = 0;
  bit        stim_done = 1'b0;
  bit        hold_out = 1'b0;
  bit        in_fire = 1'b0;
  int        status_seen[9];

  task automatic cache_reset();
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      c_dev[i] = '0; c_blk[i] = BLK_W'(i); c_asg[i] = 1'b0; c_fl[i] = '0;
      c_busy[i] = 1'b0; c_want[i] = 1'b0; c_done[i] = 1'b0;
      lru_next[i] = (i + 1) % BUFFER_COUNT;
      lru_prev[i] = (i + BUFFER_COUNT - 1) % BUFFER_COUNT;
    end
    lru_head = 0; lru_tail = BUFFER_COUNT - 1; lru_count = BUFFER_COUNT;
  endtask

  function automatic void lru_unlink(int i);
    if (lru_count == 0) return;
    if (lru_count == 1) begin
      lru_count = 0;
      return;
    end
    if (i == lru_head) lru_head = lru_next[i];
    else if (i == lru_tail) lru_tail = lru_prev[i];
    else begin
      lru_next[lru_prev[i]] = lru_next[i];
      lru_prev[lru_next[i]] = lru_prev[i];
    end
    lru_count--;
  endfunction

  function automatic void lru_link(int i, bit at_head);
    if (lru_count == 0) begin
      lru_head = i; lru_tail = i;
    end else if (at_head) begin
      lru_next[i] = lru_head; lru_prev[lru_head] = i; lru_head = i;
    end else begin
      lru_prev[i] = lru_tail; lru_next[lru_tail] = i; lru_tail = i;
    end
    lru_count++;
  endfunction

  function automatic void free_entry(int i, logic [7:0] extra, ref result_t r);
    bit aged;
    c_fl[i] |= extra;
    if (!c_busy[i]) lru_unlink(i);
    c_busy[i] = 1'b0;
    r.wo = c_want[i];
    c_want[i] = 1'b0;
    r.wa = (lru_count == 0);
    aged = c_fl[i][FB_AGE];
    c_fl[i][FB_AGE] = 1'b0;
    lru_link(i, aged);
  endfunction

  // updates the shadow state and returns the result this command causes
  function automatic result_t predict_result(cmd_item_t c);
    result_t r;
    int hit;
    int i;
    logic [7:0] f;
    r = '0;
    r.sts = ST_ACCEPTED;
    if (c.cmd == CMD_GET) begin
      hit = -1;
      for (int k = BUFFER_COUNT - 1; k >= 0; k--)
        if (c_asg[k] && c_dev[k] == c.dev && c_blk[k] == c.blk) hit = k;
      if (hit >= 0) begin
        r.idx = IDX_W'(hit);
        if (c_busy[hit]) begin
          c_want[hit] = 1'b1; r.sts = ST_BUSY;
        end else begin
          c_busy[hit] = 1'b1; lru_unlink(hit);
          r.sts = c_fl[hit][FB_VALID] ? ST_HIT_VALID : ST_HIT_NVALID;
        end
      end else if (lru_count == 0) begin
        r.sts = ST_NONE_FREE;
      end else begin
        i = lru_head;
        r.idx = IDX_W'(i);
        c_busy[i] = 1'b1; lru_unlink(i);
        if (c_fl[i][FB_DIRTY]) begin
          c_done[i] = 1'b0;
          c_fl[i] = (c_fl[i] & ~M_READ) | M_WRITE | M_ASYNC | M_AGE;
          r.vdev = c_dev[i]; r.vblk = c_blk[i]; r.sts = ST_WRITEBACK;
        end else begin
          c_fl[i] = '0; c_dev[i] = c.dev; c_blk[i] = c.blk; c_asg[i] = 1'b1;
          r.sts = ST_ASSIGNED;
        end
      end
    end else if (c.cmd <= CMD_COMPLETE) begin
      i = c.idx;
      r.idx = c.idx;
      case (c.cmd)
        CMD_START_RD: begin
          c_done[i] = 1'b0; c_fl[i] = ((c_fl[i] | c.xfl) & ~M_WRITE) | M_READ;
        end
        CMD_START_WR: begin
          c_done[i] = 1'b0; c_fl[i] = ((c_fl[i] | c.xfl) & ~M_READ) | M_WRITE;
        end
        CMD_RELEASE: free_entry(i, c.xfl, r);
        default: begin
          f = c_fl[i] | c.xfl;
          c_fl[i] = f;
          if (f[FB_ERROR] && f[FB_CRIT]) begin
            r.sts = ST_FATAL;
          end else begin
            if (f[FB_READ]) f |= M_VALID;
            else f &= ~M_DIRTY;
            f &= ~(M_READ | M_WRITE | M_CRIT);
            if (f[FB_ASYNC]) begin
              c_fl[i] = f & ~(M_ASYNC | M_ERROR);
              free_entry(i, '0, r);
            end else begin
              c_fl[i] = f; c_done[i] = 1'b1; c_want[i] = 1'b0; r.wo = 1'b1;
              r.sts = f[FB_ERROR] ? ST_DONE_ERR : ST_ACCEPTED;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  // driver: offers queued commands with random gaps, changes at falling edge
  int gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        n_sent++;
        void'(pending_cmds.pop_front());
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      end
      if (gap > 0) begin
        gap--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= IN_DATA_W'(pending_cmds[0]);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // predictor runs at the accepting edge and marks the acceptance for the driver
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire)
      expected_results.push_back(predict_result(cmd_item_t'(in_tdata[$bits(cmd_item_t)-1:0])));
  end

  // receiver backpressure; a hold request starts one long hold-off counted here
  int stall = 0;
  always @(negedge clk) begin
    if (hold_out) begin
      hold_out = 1'b0;
      stall = 400;
      out_tready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else if (cycle > 40000 && cycle < 60000) begin
      out_tready <= 1'b1;   // stretch with no stalls
    end else if ($urandom_range(0, 11) == 0) begin
      stall = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: compares each result transaction against the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    cycle <= cycle + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result with no command outstanding: %h", out_tdata);
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.sts <= ST_FATAL) status_seen[want.sts]++;
        if (got.sts !== want.sts) begin
          $error("status expected %0d got %0d", want.sts, got.sts); n_fail++;
        end
        if (got.idx !== want.idx) begin
          $error("result_index expected %0d got %0d", want.idx, got.idx); n_fail++;
        end
        if (got.vdev !== want.vdev) begin
          $error("victim_device expected %h got %h", want.vdev, got.vdev); n_fail++;
        end
        if (got.vblk !== want.vblk) begin
          $error("victim_block expected %h got %h", want.vblk, got.vblk); n_fail++;
        end
        if (got.wo !== want.wo) begin
          $error("wake_owner expected %0d got %0d", want.wo, got.wo); n_fail++;
        end
        if (got.wa !== want.wa) begin
          $error("wake_any expected %0d got %0d", want.wa, got.wa); n_fail++;
        end
      end
    end
  end

  function automatic cmd_item_t mk(logic [31:0] c, logic [31:0] idx, logic [31:0] d,
                                   logic [31:0] b, logic [31:0] f);
    cmd_item_t it;
    it.cmd = CMD_W'(c); it.idx = IDX_W'(idx); it.dev = DEV_W'(d); it.blk = b;
    it.xfl = XFL_W'(f);
    return it;
  endfunction

  // small tag space so gets hit often
  function automatic cmd_item_t rand_get();
    if ($urandom_range(0, 7) == 0)
      return mk(CMD_GET, $urandom, $urandom, $urandom, $urandom);
    return mk(CMD_GET, $urandom, $urandom_range(0, 2), $urandom_range(0, 40), $urandom);
  endfunction

  task automatic wait_sent();
    while (pending_cmds.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    cmd_item_t g;
    int lo;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: field extremes, every command, the listed corner cases
    pending_cmds.push_back(mk(CMD_GET, 0, 16'hFFFF, 32'hFFFF_FFFF, 5'h1F));
    pending_cmds.push_back(mk(CMD_GET, 0, 16'hFFFF, 32'hFFFF_FFFF, 0));   // busy hit
    pending_cmds.push_back(mk(CMD_GET, 0, 0, 1, 0));       // unassigned tag never matches
    pending_cmds.push_back(mk(CMD_START_RD, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_COMPLETE, 0, 0, 0, 0));  // sync completion, wake owner
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_GET, 63, 16'hFFFF, 32'hFFFF_FFFF, 0)); // valid hit
    pending_cmds.push_back(mk(CMD_START_WR, 1, 0, 0, 5'h01));
    pending_cmds.push_back(mk(CMD_RELEASE, 1, 0, 0, 5'h01)); // release of a busy entry, marked dirty
    pending_cmds.push_back(mk(CMD_START_WR, 2, 0, 0, 5'h04));
    pending_cmds.push_back(mk(CMD_COMPLETE, 2, 0, 0, 0));  // done with error
    pending_cmds.push_back(mk(CMD_COMPLETE, 3, 0, 0, 5'h14)); // critical error
    pending_cmds.push_back(mk(CMD_RELEASE, 4, 0, 0, 5'h02)); // aged to the head
    pending_cmds.push_back(mk(CMD_GET, 0, 7, 7, 0));
    pending_cmds.push_back(mk(5, 9, 16'h1234, 32'h5678, 5'h1F)); // unknown commands
    pending_cmds.push_back(mk(6, 63, 0, 0, 0));
    pending_cmds.push_back(mk(7, 0, 16'hFFFF, 32'hFFFF_FFFF, 5'h1F));
    wait_drained();

    // fill the whole pool so gets see no free entry, then release with wake_any
    for (int k = 0; k < 70; k++)
      pending_cmds.push_back(mk(CMD_GET, 0, 16'h00AA, k + 100, 0));
    // sender pauses until every result is back
    wait_drained();
    pending_cmds.push_back(mk(CMD_RELEASE, 5, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_RELEASE, 6, 0, 0, 5'h08));
    pending_cmds.push_back(mk(CMD_GET, 0, 16'h00AA, 200, 0));
    pending_cmds.push_back(mk(CMD_GET, 0, 16'h00AA, 200, 0));
    // dirty free entries then trigger async write-back and auto release
    pending_cmds.push_back(mk(CMD_RELEASE, 7, 0, 0, 5'h01));
    pending_cmds.push_back(mk(CMD_GET, 0, 16'h00BB, 1, 0));
    pending_cmds.push_back(mk(CMD_COMPLETE, 7, 0, 0, 0));
    for (int k = 0; k < BUFFER_COUNT; k++)
      pending_cmds.push_back(mk(CMD_RELEASE, k, 0, 0, $urandom));
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_out = 1'b1;
    repeat (2) @(posedge clk);
    for (int k = 0; k < 20; k++) pending_cmds.push_back(rand_get());
    wait_drained();

    // random part: mostly get/start/complete/release lifecycles on live entries
    lo = 0;
    while (lo < 780) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          g = rand_get();
          pending_cmds.push_back(g);
          lo++;
        end
        3, 4: begin
          int e;
          e = $urandom_range(0, BUFFER_COUNT - 1);
          pending_cmds.push_back(mk($urandom_range(0, 1) ? CMD_START_RD : CMD_START_WR,
                                    e, $urandom, $urandom, $urandom_range(0, 15)));
          pending_cmds.push_back(mk(CMD_COMPLETE, e, $urandom, $urandom,
                                    ($urandom_range(0, 5) == 0) ? $urandom : 0));
          lo += 2;
        end
        5, 6, 7: begin
          pending_cmds.push_back(mk(CMD_RELEASE, $urandom_range(0, BUFFER_COUNT - 1),
                                    $urandom, $urandom, $urandom));
          lo++;
        end
        8: begin
          pending_cmds.push_back(mk($urandom_range(0, 7), $urandom, $urandom, $urandom,
                                    $urandom));
          lo++;
        end
        default: begin
          pending_cmds.push_back(mk(CMD_COMPLETE, $urandom_range(0, BUFFER_COUNT - 1),
                                    $urandom, $urandom, $urandom_range(0, 15)));
          lo++;
        end
      endcase
      if (pending_cmds.size() > 16) wait_sent();
    end
    wait_drained();
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    cache_reset();
    wait (stim_done || cycle >= LIMIT_CYCLES);
    if (!stim_done) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      $display("covered %0d commands, %0d results checked; hits %0d/%0d assigned %0d",
               n_sent, n_checked, status_seen[0], status_seen[1], status_seen[2]);
      $display("busy %0d none-free %0d write-back %0d error %0d fatal %0d",
               status_seen[3], status_seen[4], status_seen[5], status_seen[7],
               status_seen[8]);
      if (n_fail == 0 && expected_results.size() == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
      $finish;
    end
  end
endmodule
